### hdl/arpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_pkg: shared types and constants of the ARP responder
// Holds the payload structs, the controller state type and the protocol codes.
// ----------------------------------------------------------------------------
package arpr_pkg;

  // Address table geometry.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd1;

  // Input command codes.
  localparam logic CMD_RX_PACKET = 1'b0;
  localparam logic CMD_ISSUE_REQ = 1'b1;

  // Received ARP operation low byte and protocol type.
  localparam logic [7:0]  RX_OP_REQUEST = 8'd1;
  localparam logic [7:0]  RX_OP_REPLY   = 8'd2;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;

  // Transmit operation codes.
  localparam logic [1:0] TX_OP_NONE    = 2'd0;
  localparam logic [1:0] TX_OP_REQUEST = 2'd1;
  localparam logic [1:0] TX_OP_REPLY   = 2'd2;

  // Table status codes.
  localparam logic [1:0] TBL_NONE     = 2'd0;
  localparam logic [1:0] TBL_UPDATED  = 2'd1;
  localparam logic [1:0] TBL_APPENDED = 2'd2;
  localparam logic [1:0] TBL_DROPPED  = 2'd3;

  localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  oper_low;
    logic [15:0] proto_type;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] dest_ip;
    logic [31:0] request_ip;
  } arpr_in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [1:0]  tx_oper;
    logic [47:0] tx_sender_mac;
    logic [31:0] tx_sender_ip;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_dest_ip;
    logic [1:0]  table_status;
  } arpr_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } arpr_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_step;
    logic wr_update;
    logic wr_append;
    logic set_drop;
    logic load_out;
  } arpr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic do_learn;
    logic hit;
    logic miss;
    logic full;
    logic out_free;
  } arpr_status_t;

endpackage

### hdl/arpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_ctrl: sequencing controller of the ARP responder
// Steps one transaction through decode, table scan and result hand-off.
// ----------------------------------------------------------------------------
module arpr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  arpr_pkg::arpr_status_t sts,
  output arpr_pkg::arpr_cmd_t    cmd
);

  arpr_pkg::arpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      arpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = arpr_pkg::ST_DECIDE;
        end
      end
      arpr_pkg::ST_DECIDE: begin
        state_nxt = sts.do_learn ? arpr_pkg::ST_SCAN : arpr_pkg::ST_FINISH;
      end
      arpr_pkg::ST_SCAN: begin
        if (sts.hit || sts.miss) begin
          state_nxt = arpr_pkg::ST_FINISH;
        end
      end
      arpr_pkg::ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = arpr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = arpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      arpr_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      arpr_pkg::ST_DECIDE: begin
        cmd.scan_start = 1'b1;
      end
      arpr_pkg::ST_SCAN: begin
        // The read pipeline keeps stepping; the first hit in scan order wins.
        cmd.scan_step = 1'b1;
        if (sts.hit) begin
          cmd.wr_update = 1'b1;
        end else if (sts.miss) begin
          cmd.wr_append = !sts.full;
          cmd.set_drop  = sts.full;
        end
      end
      arpr_pkg::ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/arpr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_dp: datapath of the ARP responder
// Holds the configuration, the address table, the scan pipeline and the
// output register.
// ----------------------------------------------------------------------------
module arpr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  arpr_pkg::arpr_in_t                in_data,
  input  logic                              cfg_valid,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [47:0]                       cfg_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output arpr_pkg::arpr_out_t               out_data,
  input  arpr_pkg::arpr_cmd_t               cmd,
  output arpr_pkg::arpr_status_t            sts
);

  localparam int IW = arpr_pkg::IDX_W;
  localparam int CW = arpr_pkg::CNT_W;

  logic [47:0]         own_mac_r;
  logic [31:0]         own_ip_r;
  arpr_pkg::arpr_in_t  item_r;
  logic [1:0]          status_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       rd_idx_r;
  logic [IW-1:0]       cmp_idx_r;
  logic                cmp_vld_r;
  logic [47:0]         rd_hw_r;
  logic                out_valid_r;
  arpr_pkg::arpr_out_t out_data_r;

  logic [47:0] hw_mem [arpr_pkg::TABLE_DEPTH];
  logic [31:0] ip_mem [arpr_pkg::TABLE_DEPTH];

  logic                is_reply_req;
  logic                cnt_zero;
  logic                last_cmp;
  logic                match;
  arpr_pkg::arpr_out_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r <= '0;
      own_ip_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        arpr_pkg::REG_OWN_MAC: own_mac_r <= cfg_data;
        arpr_pkg::REG_OWN_IP:  own_ip_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  assign is_reply_req = (item_r.cmd == arpr_pkg::CMD_RX_PACKET)
                     && (item_r.oper_low == arpr_pkg::RX_OP_REQUEST)
                     && (item_r.proto_type == arpr_pkg::PTYPE_IPV4)
                     && (item_r.dest_ip == own_ip_r);

  assign sts.do_learn = is_reply_req
                     || ((item_r.cmd == arpr_pkg::CMD_RX_PACKET)
                         && (item_r.oper_low == arpr_pkg::RX_OP_REPLY));

  // Scan pipeline: one table read issued per cycle; the read data is registered and compared in the next cycle.
  assign cnt_zero = (count_r == '0);
  assign match    = cmp_vld_r && (rd_hw_r == item_r.sender_mac);
  assign last_cmp = cmp_vld_r && ((CW'(cmp_idx_r) + CW'(1)) == count_r);

  assign sts.hit  = match;
  assign sts.miss = cnt_zero || (last_cmp && !match);
  assign sts.full = (count_r == CW'(arpr_pkg::TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (rd_idx_r < count_r) begin
        rd_idx_r  <= rd_idx_r + CW'(1);
        cmp_vld_r <= 1'b1;
      end else begin
        cmp_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && (rd_idx_r < count_r)) begin
      rd_hw_r   <= hw_mem[rd_idx_r[IW-1:0]];
      cmp_idx_r <= rd_idx_r[IW-1:0];
    end
  end

  // Table memory writes: an update rewrites only the IP of the hit entry.
  always_ff @(posedge clk) begin
    if (cmd.wr_update) begin
      ip_mem[cmp_idx_r] <= item_r.sender_ip;
    end else if (cmd.wr_append) begin
      hw_mem[count_r[IW-1:0]] <= item_r.sender_mac;
      ip_mem[count_r[IW-1:0]] <= item_r.sender_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_append) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      status_r <= arpr_pkg::TBL_NONE;
    end else if (cmd.wr_update) begin
      status_r <= arpr_pkg::TBL_UPDATED;
    end else if (cmd.wr_append) begin
      status_r <= arpr_pkg::TBL_APPENDED;
    end else if (cmd.set_drop) begin
      status_r <= arpr_pkg::TBL_DROPPED;
    end
  end

  // Result formation.
  always_comb begin
    result              = '0;
    result.table_status = status_r;
    if (item_r.cmd == arpr_pkg::CMD_ISSUE_REQ) begin
      result.tx_valid      = 1'b1;
      result.tx_oper       = arpr_pkg::TX_OP_REQUEST;
      result.tx_sender_mac = own_mac_r;
      result.tx_sender_ip  = own_ip_r;
      result.tx_target_mac = arpr_pkg::MAC_BROADCAST;
      result.tx_dest_ip    = item_r.request_ip;
    end else if (is_reply_req) begin
      result.tx_valid      = 1'b1;
      result.tx_oper       = arpr_pkg::TX_OP_REPLY;
      result.tx_sender_mac = own_mac_r;
      result.tx_sender_ip  = item_r.dest_ip;
      result.tx_target_mac = item_r.sender_mac;
      result.tx_dest_ip    = item_r.sender_ip;
    end
  end

  // Output register.
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/arp_responder_with_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_responder_with_table: ARP engine for IPv4 over Ethernet
// Answers ARP requests for the own IP, learns MAC/IP pairs and issues requests.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one transaction
//   per decoded ARP packet or per issue-request command. Each input
//   transaction produces exactly one output transaction on out_valid,
//   out_stall and out_data, in order.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   sets own_mac (index 0) and own_ip (index 1); cfg_ready is always high.
//   Write configuration only while no transaction is in flight.
//   Timing: one transaction at a time. A command or an ignored packet passes
//   from acceptance through the decide state to the result register. A
//   learning packet scans the table through a registered read port, one
//   entry issued per cycle, and stops at the hit or, on a miss, after the
//   last entry below the count (all entries with a full 16-entry table). The
//   next transaction is accepted the cycle after the result is loaded, even
//   while that result still waits on out_stall.
//   Reset clears the configuration, the entry count and the output valid;
//   table contents are not cleared, only entries below the count are read.
//   While out_stall is high the result holds; a following transaction is
//   processed and then waits in the controller until the output frees up.
// ----------------------------------------------------------------------------
module arp_responder_with_table (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  arpr_pkg::arpr_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output arpr_pkg::arpr_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [47:0]                    cfg_data
);

  arpr_pkg::arpr_cmd_t    cmd;
  arpr_pkg::arpr_status_t sts;

  // Configuration registers are simple flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // The controller owns the input handshake and sequences the datapath.
  arpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the table, configuration and output register.
  arpr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hdl/arpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_checker: port-level checks of the ARP responder
// Watches the top-level ports and is attached by a bind statement.
// ----------------------------------------------------------------------------
module arpr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input arpr_pkg::arpr_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_oper: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.tx_valid == (out_data.tx_oper != arpr_pkg::TX_OP_NONE)))
    else $error("tx_valid disagrees with tx_oper");

  a_request_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.tx_oper == arpr_pkg::TX_OP_REQUEST) |->
      (out_data.tx_target_mac == arpr_pkg::MAC_BROADCAST)
      && (out_data.table_status == arpr_pkg::TBL_NONE))
    else $error("issued request is malformed or touched the table");

  a_silent_learn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |->
      (out_data.tx_sender_mac == '0) && (out_data.tx_target_mac == '0)
      && (out_data.tx_sender_ip == '0) && (out_data.tx_dest_ip == '0))
    else $error("address fields not cleared without a packet");

endmodule

bind arp_responder_with_table arpr_checker u_arpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/tb_arp_responder_with_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_responder_with_table: self-checking bench for the ARP responder
// Drives received ARP packets and issue-request commands into the engine.
// A scoreboard keeps its own copy of the address table and configuration,
// predicts every result and compares each output transaction field by field.
// Both channels idle at random, and the receiver also holds off for a long
// stretch. A short directed sequence comes first, then four random phases
// run under different own_mac and own_ip settings.
// ----------------------------------------------------------------------------
module tb_arp_responder_with_table;

  // Scoreboard: a behavioral copy of the engine plus the queue of predicted
  // output transactions, oldest first.
  class arp_scoreboard;
    logic [47:0]         own_mac;
    logic [31:0]         own_ip;
    logic [47:0]         hw_tab [arpr_pkg::TABLE_DEPTH];
    logic [31:0]         ip_tab [arpr_pkg::TABLE_DEPTH];
    int unsigned         n_entries;
    arpr_pkg::arpr_out_t expected_q [$];
    int                  errors;

    function new();
      own_mac   = '0;
      own_ip    = '0;
      n_entries = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [arpr_pkg::CFG_IDX_W-1:0] idx, logic [47:0] d);
      case (idx)
        arpr_pkg::REG_OWN_MAC: own_mac = d;
        arpr_pkg::REG_OWN_IP:  own_ip  = d[31:0];
        default: ;
      endcase
    endfunction

    // Search by hardware address. A hit rewrites the IP, a miss appends while
    // there is room and is dropped once the table is full.
    function logic [1:0] learn_pair(logic [47:0] mac, logic [31:0] ip);
      for (int i = 0; i < n_entries; i++) begin
        if (hw_tab[i] == mac) begin
          ip_tab[i] = ip;
          return arpr_pkg::TBL_UPDATED;
        end
      end
      if (n_entries >= arpr_pkg::TABLE_DEPTH) return arpr_pkg::TBL_DROPPED;
      hw_tab[n_entries] = mac;
      ip_tab[n_entries] = ip;
      n_entries++;
      return arpr_pkg::TBL_APPENDED;
    endfunction

    // Called for every accepted input transaction.
    function void note_item(arpr_pkg::arpr_in_t it);
      arpr_pkg::arpr_out_t res;
      res = '0;
      if (it.cmd == arpr_pkg::CMD_ISSUE_REQ) begin
        res.tx_valid      = 1'b1;
        res.tx_oper       = arpr_pkg::TX_OP_REQUEST;
        res.tx_sender_mac = own_mac;
        res.tx_sender_ip  = own_ip;
        res.tx_target_mac = arpr_pkg::MAC_BROADCAST;
        res.tx_dest_ip    = it.request_ip;
      end else if (it.oper_low == arpr_pkg::RX_OP_REQUEST) begin
        if (it.proto_type == arpr_pkg::PTYPE_IPV4 && it.dest_ip == own_ip) begin
          res.table_status  = learn_pair(it.sender_mac, it.sender_ip);
          res.tx_valid      = 1'b1;
          res.tx_oper       = arpr_pkg::TX_OP_REPLY;
          res.tx_sender_mac = own_mac;
          res.tx_sender_ip  = it.dest_ip;
          res.tx_target_mac = it.sender_mac;
          res.tx_dest_ip    = it.sender_ip;
        end
      end else if (it.oper_low == arpr_pkg::RX_OP_REPLY) begin
        res.table_status = learn_pair(it.sender_mac, it.sender_ip);
      end
      expected_q.push_back(res);
    endfunction

    function void cmp(string fname, logic [47:0] want, logic [47:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_result(arpr_pkg::arpr_out_t got);
      arpr_pkg::arpr_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      cmp("tx_valid", 48'(want.tx_valid), 48'(got.tx_valid));
      cmp("tx_oper", 48'(want.tx_oper), 48'(got.tx_oper));
      cmp("tx_sender_mac", want.tx_sender_mac, got.tx_sender_mac);
      cmp("tx_sender_ip", 48'(want.tx_sender_ip), 48'(got.tx_sender_ip));
      cmp("tx_target_mac", want.tx_target_mac, got.tx_target_mac);
      cmp("tx_dest_ip", 48'(want.tx_dest_ip), 48'(got.tx_dest_ip));
      cmp("table_status", 48'(want.table_status), 48'(got.table_status));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  arpr_pkg::arpr_in_t             in_data;
  logic                           out_valid;
  logic                           out_stall;
  arpr_pkg::arpr_out_t            out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [arpr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [47:0]                    cfg_data;

  arp_scoreboard sb = new();

  // Idle controls of the sender and the receiver processes.
  bit no_idle   = 1'b1;
  int stall_pct = 0;
  bit hold_req  = 1'b0;

  always #10 clk = ~clk;

  arp_responder_with_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Output monitor. Signals are read right at the edge, so they still hold
  // the values that the flops of the block and the bench sampled.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver. Each pass drives out_stall once and holds it until the next
  // pass. A hold request keeps the output stalled for a long stretch,
  // which fills the engine and pushes back on the sender.
  always begin
    if (hold_req) begin
      out_stall <= 1'b1;
      hold_req = 1'b0;
      repeat (400) @(posedge clk);
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      if ($urandom_range(99) < 85) repeat ($urandom_range(4, 1)) @(posedge clk);
      else repeat ($urandom_range(40, 10)) @(posedge clk);
    end else begin
      out_stall <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  end

  // Global watchdog. A correct run ends well before this.
  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Sender gap: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic arpr_pkg::arpr_in_t rx_item(logic [7:0] op, logic [15:0] pt,
                                                 logic [47:0] mac, logic [31:0] sip,
                                                 logic [31:0] tip);
    arpr_pkg::arpr_in_t it;
    it.cmd        = arpr_pkg::CMD_RX_PACKET;
    it.oper_low   = op;
    it.proto_type = pt;
    it.sender_mac = mac;
    it.sender_ip  = sip;
    it.dest_ip    = tip;
    it.request_ip = $urandom;
    return it;
  endfunction

  // A hardware address to learn: mostly one already in the table, so that
  // hits land at every scan position, otherwise a fresh one.
  function automatic logic [47:0] learn_mac();
    if (sb.n_entries != 0 && $urandom_range(99) < 60)
      return sb.hw_tab[$urandom_range(sb.n_entries - 1)];
    return rand_mac();
  endfunction

  // Random transaction. Most are well formed with random content; the rest
  // are requests aimed elsewhere or with a random protocol type, and pure noise.
  function automatic arpr_pkg::arpr_in_t make_item();
    arpr_pkg::arpr_in_t it;
    int                 r;
    it = rx_item(8'($urandom), 16'($urandom), rand_mac(), $urandom, $urandom);
    r  = $urandom_range(99);
    if (r < 15) begin
      it.cmd = arpr_pkg::CMD_ISSUE_REQ;
    end else if (r < 45) begin
      it = rx_item(arpr_pkg::RX_OP_REQUEST, arpr_pkg::PTYPE_IPV4, learn_mac(), $urandom,
                   sb.own_ip);
    end else if (r < 70) begin
      it = rx_item(arpr_pkg::RX_OP_REPLY,
                   ($urandom_range(1)) ? arpr_pkg::PTYPE_IPV4 : 16'($urandom),
                   learn_mac(), $urandom, $urandom);
    end else if (r < 80) begin
      it.oper_low = arpr_pkg::RX_OP_REQUEST;
      if ($urandom_range(1)) begin
        it.proto_type = arpr_pkg::PTYPE_IPV4;
        it.dest_ip    = sb.own_ip ^ (32'd1 << $urandom_range(31));
      end else begin
        it.dest_ip = sb.own_ip;
      end
    end
    return it;
  endfunction

  // Offers one input transaction, entered just after a rising edge. The
  // valid is lowered only when a gap is taken, so it is never lowered and
  // raised in the same step.
  task automatic send_item(input arpr_pkg::arpr_in_t it);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic write_cfg(input logic [arpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [47:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted result has been seen, then lets the engine
  // settle before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Directed sequence: field extremes, both commands, ignored packets, and
  // the table going from empty through full to dropping.
  task automatic directed_seq();
    arpr_pkg::arpr_in_t it;
    it            = '1;
    it.cmd        = arpr_pkg::CMD_ISSUE_REQ;
    it.request_ip = '0;
    send_item(it);
    it            = '0;
    it.cmd        = arpr_pkg::CMD_ISSUE_REQ;
    it.request_ip = '1;
    send_item(it);
    // Appends at both address extremes, then a hit that keeps the same IP.
    send_item(rx_item(arpr_pkg::RX_OP_REQUEST, arpr_pkg::PTYPE_IPV4, 48'h0, 32'h0,
                      sb.own_ip));
    send_item(rx_item(arpr_pkg::RX_OP_REQUEST, arpr_pkg::PTYPE_IPV4, '1, '1, sb.own_ip));
    send_item(rx_item(arpr_pkg::RX_OP_REPLY, arpr_pkg::PTYPE_IPV4, 48'h0, 32'h0,
                      $urandom));
    // Requests with the wrong protocol type or aimed at another station.
    send_item(rx_item(arpr_pkg::RX_OP_REQUEST, 16'h0806, rand_mac(), $urandom,
                      sb.own_ip));
    send_item(rx_item(arpr_pkg::RX_OP_REQUEST, arpr_pkg::PTYPE_IPV4, rand_mac(),
                      $urandom, ~sb.own_ip));
    // A reply is learned whatever its protocol type says.
    send_item(rx_item(arpr_pkg::RX_OP_REPLY, 16'hFFFF, rand_mac(), $urandom, $urandom));
    // Unknown operation bytes.
    send_item(rx_item(8'h00, arpr_pkg::PTYPE_IPV4, rand_mac(), $urandom, sb.own_ip));
    send_item(rx_item(8'hFF, arpr_pkg::PTYPE_IPV4, rand_mac(), $urandom, sb.own_ip));
    // Fill the table, then overflow it through both learning paths.
    while (sb.n_entries < arpr_pkg::TABLE_DEPTH) begin
      if (sb.n_entries[0])
        send_item(rx_item(arpr_pkg::RX_OP_REPLY, arpr_pkg::PTYPE_IPV4, rand_mac(),
                          $urandom, $urandom));
      else
        send_item(rx_item(arpr_pkg::RX_OP_REQUEST, arpr_pkg::PTYPE_IPV4, rand_mac(),
                          $urandom, sb.own_ip));
    end
    send_item(rx_item(arpr_pkg::RX_OP_REPLY, arpr_pkg::PTYPE_IPV4, rand_mac(), $urandom,
                      $urandom));
    send_item(rx_item(arpr_pkg::RX_OP_REQUEST, arpr_pkg::PTYPE_IPV4, rand_mac(),
                      $urandom, sb.own_ip));
    // A hit on the last entry walks the whole table.
    send_item(rx_item(arpr_pkg::RX_OP_REPLY, arpr_pkg::PTYPE_IPV4,
                      sb.hw_tab[arpr_pkg::TABLE_DEPTH-1], $urandom, $urandom));
  endtask

  initial begin
    arpr_pkg::arpr_in_t it;
    int                 counted;
    logic [47:0]        mac_val;
    logic [31:0]        ip_val;

    // All inputs start known while reset is held.
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= arpr_pkg::REG_OWN_MAC;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_cfg(arpr_pkg::REG_OWN_MAC, rand_mac());
    write_cfg(arpr_pkg::REG_OWN_IP, {16'h0, $urandom});
    directed_seq();

    // Random phases. Each starts from an idle engine with a new configuration:
    // all ones, all zeros, then two random settings.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin mac_val = '1; ip_val = '1; end
        1: begin mac_val = '0; ip_val = '0; end
        default: begin mac_val = rand_mac(); ip_val = $urandom; end
      endcase
      write_cfg(arpr_pkg::REG_OWN_MAC, mac_val);
      write_cfg(arpr_pkg::REG_OWN_IP, {16'h0, ip_val});

      // The first phase runs back to back with no idling on either side.
      no_idle   = (phase == 0);
      stall_pct = (phase == 0) ? 0 : (phase == 1) ? 30 : (phase == 2) ? 50 : 15;

      counted = 0;
      while (counted < 200) begin
        // Partway through the second phase the receiver stops for a long
        // stretch while transactions keep coming.
        if (phase == 1 && counted == 40) hold_req = 1'b1;
        it = make_item();
        counted++;
        send_item(it);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
